### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

### rtl/ppcc_pkg.sv
// Types and constants of the palette pixel channel converter
`default_nettype none

package ppcc_pkg;

  localparam int BYTE_W     = 8;
  localparam int COMP_W     = 3 * BYTE_W;
  localparam int DIM_W      = 13;
  localparam int DIM_MAX    = (2 ** DIM_W) - 1;
  localparam int PAD_W      = 2;
  localparam int PROD_W     = 16;
  localparam int IN_DATA_W  = 5 * BYTE_W;
  localparam int OUT_DATA_W = 4 * BYTE_W;
  localparam int CFG_IDX_W  = 2;

  // luma weights, 0.3 / 0.59 / 0.11 in unsigned Q0.8
  localparam logic [BYTE_W-1:0] LUMA_W_FIRST  = 8'd77;
  localparam logic [BYTE_W-1:0] LUMA_W_SECOND = 8'd151;
  localparam logic [BYTE_W-1:0] LUMA_W_THIRD  = 8'd28;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    MODE_GRAY   = 3'd0,
    MODE_ALL    = 3'd1,
    MODE_FIRST  = 3'd2,
    MODE_SECOND = 3'd3,
    MODE_THIRD  = 3'd4,
    MODE_SUM    = 3'd5,
    MODE_RG     = 3'd6,
    MODE_YB     = 3'd7
  } mode_t;

  typedef enum logic {
    KIND_PALETTE = 1'b0,
    KIND_PIXEL   = 1'b1
  } kind_t;

  // what the counters say about the byte now on the input
  typedef struct packed {
    logic emit;
    logic last;
  } item_status_t;

  // side information travelling with a table read
  typedef struct packed {
    logic [BYTE_W-1:0] pix;
    logic              gray_ramp;
    logic              last;
    logic              in_range;
  } pix_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/palette_pixel_channel_converter_top.sv
// Palette pixel channel converter, top level
//
//  channel   dir  moves                                 per transfer
//  s_axis    in   palette entries and pixel stream bytes one item
//  m_axis    out  looked-up pixel with channel value     one result
//  cfg       in   mode, image width, image height        one register
//
// One item per cycle while s_axis_tready is high. A pixel's result is offered on m_axis
// after its transfer in has passed the colour table read at the accepting edge, the
// weighting products, then the output register.
// Palette loads and pad bytes give no result. Reset is synchronous and clears
// control state only; the colour table holds nothing until loaded.
// A stall on m_axis fills the output register and the two stages behind it
// before s_axis_tready drops.
`default_nettype none

`include "assert_macros.svh"

module palette_pixel_channel_converter_top #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_DIMENSION   = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, comp_first, comp_second, comp_third, pixel_byte from bit 0 up
  input  logic [ppcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value, out_first, out_second, out_third from bit 0 up
  output logic [ppcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // end_of_image
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [ppcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppcc_pkg::DIM_W-1:0]      cfg_data
);

  import ppcc_pkg::*;

  localparam int ADDR_W  = $clog2(PALETTE_ENTRIES);
  localparam int DIM_CAP = (MAX_DIMENSION > DIM_MAX) ? DIM_MAX : MAX_DIMENSION;
  localparam logic [DIM_W-1:0]  DIM_CAP_V = DIM_W'(DIM_CAP);
  localparam logic [BYTE_W:0]   ENTRIES_V = (BYTE_W+1)'(PALETTE_ENTRIES);

  // configuration, held already clamped
  mode_t            mode;
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [PAD_W-1:0] pad_due;

  kind_t             kind;
  logic [BYTE_W-1:0] entry_index, comp_first, comp_second, comp_third, pixel_byte;
  logic              entry_in_range, pix_in_range;
  logic              s_accept;
  logic              mem_wr;
  logic              s1_load;
  logic              s1_move;
  logic              calc_ready;
  logic [DIM_W-1:0]  width_next;

  item_status_t      status;
  logic              gray_ramp;

  logic              s1_valid;
  pix_ctrl_t         s1_ctrl;
  logic [COMP_W-1:0] rd_data;

  always_comb begin
    kind        = kind_t'(s_axis_tuser);
    entry_index = s_axis_tdata[BYTE_W-1:0];
    comp_first  = s_axis_tdata[2*BYTE_W-1:BYTE_W];
    comp_second = s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
    comp_third  = s_axis_tdata[4*BYTE_W-1:3*BYTE_W];
    pixel_byte  = s_axis_tdata[5*BYTE_W-1:4*BYTE_W];

    entry_in_range = {1'b0, entry_index} < ENTRIES_V;
    pix_in_range   = {1'b0, pixel_byte} < ENTRIES_V;

    s1_move       = s1_valid && calc_ready;
    s_axis_tready = !s1_valid || calc_ready;
    s_accept      = s_axis_tvalid && s_axis_tready;
    mem_wr        = s_accept && (kind == KIND_PALETTE) && entry_in_range;
    s1_load       = s_accept && (kind == KIND_PIXEL) && status.emit;

    width_next = clamp_dim(cfg_data, DIM_CAP_V);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_GRAY;
      width   <= DIM_W'(1);
      height  <= DIM_W'(1);
      pad_due <= PAD_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode <= mode_t'(cfg_data[2:0]);
        CFG_WIDTH: begin
          width   <= width_next;
          // pad bytes up to the next multiple of four
          pad_due <= ~width_next[PAD_W-1:0] + PAD_W'(1);
        end
        CFG_HEIGHT: height <= width_next;
        default: ;
      endcase
    end
  end

  ppcc_frame_ctrl u_frame_ctrl (
    .clk            (clk),
    .rst            (rst),
    .acc            (s_accept),
    .kind           (kind),
    .entry_index    (entry_index),
    .entry_in_range (entry_in_range),
    .comp_first     (comp_first),
    .comp_second    (comp_second),
    .comp_third     (comp_third),
    .width          (width),
    .height         (height),
    .pad_due        (pad_due),
    .status         (status),
    .gray_ramp      (gray_ramp)
  );

  // writes and reads come from different transfers, so no same-edge clash
  ppcc_palette_mem #(
    .DEPTH  (PALETTE_ENTRIES),
    .ADDR_W (ADDR_W),
    .DATA_W (COMP_W)
  ) u_palette_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (entry_index[ADDR_W-1:0]),
    .wr_data ({comp_first, comp_second, comp_third}),
    .rd_en   (s1_load),
    .rd_addr (pixel_byte[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctrl.pix       <= pixel_byte;
      s1_ctrl.gray_ramp <= gray_ramp;
      s1_ctrl.last      <= status.last;
      s1_ctrl.in_range  <= pix_in_range;
    end
  end

  ppcc_color_calc u_color_calc (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .in_valid      (s1_valid),
    .in_ready      (calc_ready),
    .in_ctrl       (s1_ctrl),
    .in_comp       (rd_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `ASSERT_PROP(a_s1_fills, clk, rst, s1_load |=> s1_valid)
  `ASSERT_PROP(a_s1_holds, clk, rst, (s1_valid && !calc_ready) |=> (s1_valid && $stable(rd_data)))
  `ASSERT_NEVER(a_wr_read_clash, clk, rst, mem_wr && s1_load)

endmodule

`default_nettype wire

### rtl/ppcc_palette_mem.sv
// Colour table memory: one write port, one registered read port
`default_nettype none

module ppcc_palette_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low, so a stalled stage keeps its word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/ppcc_frame_ctrl.sv
// Column, row and pad counters plus the gray-ramp check
`default_nettype none

module ppcc_frame_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  ppcc_pkg::kind_t             kind,
  input  logic [ppcc_pkg::BYTE_W-1:0] entry_index,
  input  logic                        entry_in_range,
  input  logic [ppcc_pkg::BYTE_W-1:0] comp_first,
  input  logic [ppcc_pkg::BYTE_W-1:0] comp_second,
  input  logic [ppcc_pkg::BYTE_W-1:0] comp_third,
  input  logic [ppcc_pkg::DIM_W-1:0]  width,
  input  logic [ppcc_pkg::DIM_W-1:0]  height,
  input  logic [ppcc_pkg::PAD_W-1:0]  pad_due,
  output ppcc_pkg::item_status_t      status,
  output logic                        gray_ramp
);

  import ppcc_pkg::*;

  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [PAD_W-1:0] pad_count, pad_count_next;
  logic             gray_ramp_next;

  logic             col_past;
  logic             col_last;
  logic             row_last;
  logic [PAD_W-1:0] pad_inc;
  logic             pad_end;
  logic             is_ramp;
  logic [DIM_W-1:0] row_wrap;

  always_comb begin
    col_past = column_count >= width;
    col_last = ({1'b0, column_count} + (DIM_W+1)'(1)) >= {1'b0, width};
    row_last = ({1'b0, row_count} + (DIM_W+1)'(1)) >= {1'b0, height};
    pad_inc  = pad_count + PAD_W'(1);
    pad_end  = (pad_inc == '0) || (pad_inc >= pad_due);
    is_ramp  = (comp_first == entry_index) && (comp_second == entry_index) &&
               (comp_third == entry_index);
    row_wrap = row_last ? '0 : row_count + DIM_W'(1);

    status.emit = !col_past;
    status.last = col_last && row_last;

    column_count_next = column_count;
    row_count_next    = row_count;
    pad_count_next    = pad_count;
    gray_ramp_next    = gray_ramp;

    if (acc) begin
      if (kind == KIND_PALETTE) begin
        // entry 0 opens a new image
        if (entry_index == '0) begin
          column_count_next = '0;
          row_count_next    = '0;
          pad_count_next    = '0;
          gray_ramp_next    = 1'b1;
        end
        if (entry_in_range && !is_ramp) begin
          gray_ramp_next = 1'b0;
        end
      end else if (col_past) begin
        pad_count_next = pad_inc;
        if (pad_end) begin
          column_count_next = '0;
          pad_count_next    = '0;
          row_count_next    = row_wrap;
        end
      end else begin
        column_count_next = column_count + DIM_W'(1);
        if (col_last && (pad_due == '0)) begin
          column_count_next = '0;
          pad_count_next    = '0;
          row_count_next    = row_wrap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pad_count    <= '0;
      gray_ramp    <= 1'b1;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pad_count    <= pad_count_next;
      gray_ramp    <= gray_ramp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ppcc_color_calc.sv
// Weighting stage and channel select with the output register
`default_nettype none

module ppcc_color_calc (
  input  logic                            clk,
  input  logic                            rst,
  input  ppcc_pkg::mode_t                 mode,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ppcc_pkg::pix_ctrl_t             in_ctrl,
  input  logic [ppcc_pkg::COMP_W-1:0]     in_comp,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value, out_first, out_second, out_third from bit 0 up
  output logic [ppcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);

  import ppcc_pkg::*;

  logic [BYTE_W-1:0] f_in, s_in, t_in;

  logic              s2_valid;
  logic [PROD_W-1:0] s2_pf, s2_ps, s2_pt;
  logic [BYTE_W-1:0] s2_f, s2_s, s2_t, s2_pix;
  logic              s2_gray, s2_last;

  logic              out_free;
  logic              s2_load;
  logic [PROD_W-1:0] luma_sum;
  logic [BYTE_W-1:0] value;

  always_comb begin
    // indexes beyond the table read as zero components
    f_in = in_ctrl.in_range ? in_comp[3*BYTE_W-1:2*BYTE_W] : '0;
    s_in = in_ctrl.in_range ? in_comp[2*BYTE_W-1:BYTE_W]   : '0;
    t_in = in_ctrl.in_range ? in_comp[BYTE_W-1:0]          : '0;

    out_free = !m_axis_tvalid || m_axis_tready;
    in_ready = !s2_valid || out_free;
    s2_load  = in_valid && in_ready;

    // never above 255*256, so 16 bits hold it
    luma_sum = s2_pf + s2_ps + s2_pt;

    unique case (mode)
      MODE_GRAY:   value = s2_gray ? s2_pix : luma_sum[PROD_W-1:BYTE_W];
      MODE_ALL:    value = '0;
      MODE_FIRST:  value = s2_f;
      MODE_SECOND: value = s2_s;
      MODE_THIRD:  value = s2_t;
      MODE_SUM:    value = s2_f + s2_s;
      MODE_RG:     value = s2_f - s2_s;
      MODE_YB:     value = s2_f + s2_s - s2_t;
      default:     value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_pf   <= PROD_W'(LUMA_W_FIRST) * PROD_W'(f_in);
      s2_ps   <= PROD_W'(LUMA_W_SECOND) * PROD_W'(s_in);
      s2_pt   <= PROD_W'(LUMA_W_THIRD) * PROD_W'(t_in);
      s2_f    <= f_in;
      s2_s    <= s_in;
      s2_t    <= t_in;
      s2_pix  <= in_ctrl.pix;
      s2_gray <= in_ctrl.gray_ramp;
      s2_last <= in_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      m_axis_tdata <= {s2_t, s2_s, s2_f, value};
      m_axis_tlast <= s2_last;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Stream testbench for the palette pixel channel converter with a transfer-level predictor
`timescale 1ns / 1ps

module testbench;
  import ppcc_pkg::*;

  localparam int          HOLD_LEN     = 80;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 250;
  localparam int          MAX_REPORTS  = 30;
  localparam int unsigned DIM_CAP      = 4096;
  localparam int unsigned ROW_ALIGN    = 4;
  localparam int unsigned LUMA_RED     = 77;
  localparam int unsigned LUMA_GREEN   = 151;
  localparam int unsigned LUMA_BLUE    = 28;

  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] entry;
    logic [BYTE_W-1:0] c1;
    logic [BYTE_W-1:0] c2;
    logic [BYTE_W-1:0] c3;
    logic [BYTE_W-1:0] pix;
  } stream_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
    logic              last;
  } pixel_result_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [DIM_W-1:0]      cfg_data      = '0;

  // predictor state and register shadows
  logic [COMP_W-1:0] palette_mirror [256];
  logic              ramp_flag  = 1'b1;
  int unsigned       col_cnt    = 0;
  int unsigned       row_cnt    = 0;
  logic [PAD_W-1:0]  pad_cnt    = '0;
  mode_t             mode_reg   = MODE_GRAY;
  logic [DIM_W-1:0]  width_reg  = DIM_W'(1);
  logic [DIM_W-1:0]  height_reg = DIM_W'(1);

  // entries written so far, so that no pixel reads an empty slot
  bit                entry_loaded [256];
  int unsigned       loaded_list [$];

  stream_item_t      stim_q [$];
  stream_item_t      on_bus;
  pixel_result_t     pixel_expect_q [$];

  int   items_queued    = 0;
  int   items_sent      = 0;
  int   pixels_checked  = 0;
  int   err_count       = 0;
  int   phase_count     = 0;
  int   send_idle_pct   = 0;
  int   stall_pct       = 0;
  int   stall_count     = 0;
  int   quiet_cycles    = 0;
  logic long_stall_req  = 1'b0;
  logic long_stall_done = 1'b0;

  palette_pixel_channel_converter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  task automatic finish_row(input int unsigned h);
    col_cnt = 0;
    pad_cnt = '0;
    if (row_cnt + 1 >= h) row_cnt = 0;
    else row_cnt++;
  endtask

  task automatic convert_byte(input stream_item_t it, output bit emits,
                              output pixel_result_t r);
    int unsigned       w, h, pad_due, f, s, t, luma;
    logic [COMP_W-1:0] ent;
    logic [BYTE_W-1:0] v;
    w       = eff_dim(width_reg);
    h       = eff_dim(height_reg);
    pad_due = (ROW_ALIGN - w % ROW_ALIGN) % ROW_ALIGN;
    emits   = 1'b0;
    r       = '0;
    if (it.kind == KIND_PALETTE) begin
      // entry 0 opens a new image and restarts the ramp check
      if (it.entry == '0) begin
        col_cnt   = 0;
        row_cnt   = 0;
        pad_cnt   = '0;
        ramp_flag = 1'b1;
      end
      palette_mirror[it.entry] = {it.c1, it.c2, it.c3};
      if (it.c1 != it.entry || it.c2 != it.entry || it.c3 != it.entry) ramp_flag = 1'b0;
    end else if (col_cnt >= w) begin
      pad_cnt = pad_cnt + 1'b1;
      if (pad_cnt == '0 || pad_cnt >= pad_due) finish_row(h);
    end else begin
      ent  = palette_mirror[it.pix];
      f    = ent[23:16];
      s    = ent[15:8];
      t    = ent[7:0];
      luma = (LUMA_RED * f + LUMA_GREEN * s + LUMA_BLUE * t) >> 8;
      case (mode_reg)
        MODE_GRAY:   v = ramp_flag ? it.pix : 8'(luma);
        MODE_ALL:    v = '0;
        MODE_FIRST:  v = 8'(f);
        MODE_SECOND: v = 8'(s);
        MODE_THIRD:  v = 8'(t);
        MODE_SUM:    v = 8'(f + s);
        MODE_RG:     v = 8'(f - s);
        MODE_YB:     v = 8'(f + s - t);
        default:     v = '0;
      endcase
      r.value  = v;
      r.first  = ent[23:16];
      r.second = ent[15:8];
      r.third  = ent[7:0];
      r.last   = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
      emits    = 1'b1;
      col_cnt++;
      if (col_cnt >= w && pad_due == 0) finish_row(h);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODE:   mode_reg   = mode_t'(data[2:0]);
      CFG_WIDTH:  width_reg  = data;
      CFG_HEIGHT: height_reg = data;
      default:    ;
    endcase
  endtask

  task automatic push_entry(input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] c1,
                            input logic [BYTE_W-1:0] c2, input logic [BYTE_W-1:0] c3);
    stream_item_t it;
    it.kind  = KIND_PALETTE;
    it.entry = idx;
    it.c1    = c1;
    it.c2    = c2;
    it.c3    = c3;
    it.pix   = 8'($urandom);
    stim_q.push_back(it);
    items_queued++;
    if (!entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] pix);
    stream_item_t it;
    it.kind  = KIND_PIXEL;
    it.entry = 8'($urandom);
    it.c1    = 8'($urandom);
    it.c2    = 8'($urandom);
    it.c3    = 8'($urandom);
    it.pix   = pix;
    stim_q.push_back(it);
    items_queued++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_pixel();
    return 8'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  // entries 0..n-1; ramp_pct of them equal to their own index
  task automatic load_palette(input int n, input int ramp_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < ramp_pct) push_entry(8'(i), 8'(i), 8'(i), 8'(i));
      else push_entry(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic send_rows(input int unsigned w, input int unsigned rows);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) push_byte(pick_pixel());
      repeat ((ROW_ALIGN - w % ROW_ALIGN) % ROW_ALIGN) push_byte(pick_pixel());
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || s_axis_tvalid || pixel_expect_q.size() != 0)
      @(negedge clk);
    // pad bytes and palette loads may still be in the pipe
    repeat (6) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    pixel_result_t res;
    bit            emits;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_sent++;
        convert_byte(on_bus, emits, res);
        if (emits) pixel_expect_q.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.pix, on_bus.c3, on_bus.c2, on_bus.c1, on_bus.entry};
          s_axis_tuser  <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_expect_q.size() == 0) begin
          report_mismatch("transfer with nothing expected", m_axis_tdata, '0);
        end else begin
          want = pixel_expect_q.pop_front();
          pixels_checked++;
          if (m_axis_tdata[7:0] !== want.value)
            report_mismatch("value", m_axis_tdata[7:0], want.value);
          if (m_axis_tdata[15:8] !== want.first)
            report_mismatch("first component", m_axis_tdata[15:8], want.first);
          if (m_axis_tdata[23:16] !== want.second)
            report_mismatch("second component", m_axis_tdata[23:16], want.second);
          if (m_axis_tdata[31:24] !== want.third)
            report_mismatch("third component", m_axis_tdata[31:24], want.third);
          if (m_axis_tlast !== want.last)
            report_mismatch("end of image", m_axis_tlast, want.last);
        end
      end
      if (long_stall_req && !long_stall_done) begin
        m_axis_tready <= 1'b0;
        stall_count++;
        if (stall_count >= HOLD_LEN) long_stall_done <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("palette_pixel_channel_converter_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned w_eff, h_eff, rows;
    int          base, pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // gray ramp passes the index through; pad bytes dropped; end of image
    write_reg(CFG_MODE, DIM_W'(MODE_GRAY));
    write_reg(CFG_WIDTH, DIM_W'(3));
    write_reg(CFG_HEIGHT, DIM_W'(2));
    @(negedge clk);
    for (int i = 0; i < 4; i++) push_entry(8'(i), 8'(i), 8'(i), 8'(i));
    push_entry(8'd255, 8'd255, 8'd255, 8'd255);
    push_byte(8'd0);
    push_byte(8'd255);
    push_byte(8'd3);
    push_byte(8'd255);
    push_byte(8'd1);
    push_byte(8'd2);
    push_byte(8'd0);
    push_byte(8'd3);
    // full-scale luma, wrap of difference and sums; these break the ramp
    push_entry(8'd7, 8'd255, 8'd255, 8'd255);
    push_entry(8'd8, 8'd0, 8'd255, 8'd0);
    push_entry(8'd9, 8'd200, 8'd100, 8'd250);
    wait_idle();
    write_reg(CFG_WIDTH, DIM_W'(4));
    write_reg(CFG_HEIGHT, DIM_W'(2));
    for (int m = 0; m < 8; m++) begin
      wait_idle();
      write_reg(CFG_MODE, {10'($urandom), 3'(m)});
      @(negedge clk);
      push_byte((m % 2 == 0) ? 8'd7 : 8'd9);
      push_byte((m % 2 == 0) ? 8'd8 : 8'd255);
    end

    // ramp palette, then part of a row at the width cap with height 0
    wait_idle();
    write_reg(CFG_MODE, DIM_W'(MODE_GRAY));
    write_reg(CFG_WIDTH, DIM_W'(DIM_MAX));
    write_reg(CFG_HEIGHT, DIM_W'(0));
    @(negedge clk);
    load_palette(32, 100);
    repeat (24) push_byte(pick_pixel());

    // long output stall while the input keeps offering: block must back up
    wait_idle();
    write_reg(CFG_MODE, DIM_W'(MODE_YB));
    write_reg(CFG_WIDTH, DIM_W'(5));
    write_reg(CFG_HEIGHT, DIM_W'(3));
    @(negedge clk);
    load_palette(16, 0);
    send_rows(5, 6);
    long_stall_req = 1'b1;
    while (!long_stall_done) @(negedge clk);
    long_stall_req = 1'b0;

    base = items_queued;
    while (items_queued < base + RANDOM_ITEMS) begin
      wait_idle();
      phase_count++;
      case (phase_count % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 52; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      write_reg(CFG_MODE, {10'($urandom), 3'($urandom_range(7))});
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        if (pick < 8) write_reg(CFG_WIDTH, DIM_W'(0));
        else if (pick < 14) write_reg(CFG_WIDTH, DIM_W'(4));
        else write_reg(CFG_WIDTH, DIM_W'($urandom_range(1, 12)));
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        if (pick < 8) write_reg(CFG_HEIGHT, DIM_W'(0));
        else if (pick < 14) write_reg(CFG_HEIGHT, DIM_W'(DIM_MAX));
        else write_reg(CFG_HEIGHT, DIM_W'($urandom_range(1, 3)));
      end
      w_eff = eff_dim(width_reg);
      h_eff = eff_dim(height_reg);
      @(negedge clk);
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(99) < 50) begin
          case ($urandom_range(2))
            0:       load_palette($urandom_range(2, 24), 100);
            1:       load_palette($urandom_range(2, 24), 90);
            default: load_palette($urandom_range(2, 24), 0);
          endcase
        end
        // only a couple of rows when the height sits at the cap
        rows = (h_eff > 3) ? 2 : h_eff * $urandom_range(1, 2);
        send_rows(w_eff, rows);
      end else begin
        // loose bytes and stray entries; leaves rows part-done across phases
        repeat ($urandom_range(8, 30)) begin
          pick = $urandom_range(9);
          if (pick == 0)
            push_entry(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom), 8'($urandom));
          else if (pick == 1)
            push_entry(8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
          else
            push_byte(pick_pixel());
        end
      end
    end

    wait_idle();
    $display("covered %0d transfers in and %0d pixels out over %0d random phases",
             items_sent, pixels_checked, phase_count);
    $display("all eight modes, widths and heights 0 to %0d, a %0d-cycle output stall",
             DIM_MAX, HOLD_LEN);
    if (err_count == 0) begin
      $display("palette_pixel_channel_converter_top test passed");
    end else begin
      $display("palette_pixel_channel_converter_top test failed");
    end
    $finish;
  end

endmodule
